### hdl/pt2d_pkg.sv
// ----------------------------------------------------------------------------
// pt2d_pkg: shared types, constants and tables for the 2d point transform
// operation codes, result and sideband structs, cordic arctangent table
// ----------------------------------------------------------------------------
`default_nettype none

package pt2d_pkg;

  // operation codes carried on in_tuser
  typedef enum logic [2:0] {
    OP_ROTATE    = 3'd0,
    OP_TRANSLATE = 3'd1,
    OP_SCALE     = 3'd2,
    OP_REFLECT_X = 3'd3,
    OP_REFLECT_Y = 3'd4
  } pt2d_op_t;

  // guard bits kept below the output lsb inside the cordic
  localparam int unsigned GUARD = 12;
  // cordic datapath width: 32 result bits, guard bits, gain headroom
  localparam int unsigned CW = 32 + GUARD + 2;

  // angle to binary angle: floor division of (angle + offset) by 45
  localparam int unsigned       ANG_DIV  = 45;
  localparam int unsigned       ANG_HALF = 22;
  localparam int unsigned       ANG_MQ   = 47721859;          // ceil(2^31 / 45)
  localparam logic [33:0]       ANG_OFS  = 34'd2147483655;    // 45 * ANG_MQ
  localparam logic [32:0]       DIV_M    = 33'd6108397933;    // ceil(2^38 / 45)
  localparam int unsigned       DIV_SH   = 38;
  localparam int unsigned       QW       = 66 - DIV_SH;

  typedef struct packed {
    logic        sat;
    logic [31:0] y;
    logic [31:0] x;
  } pt2d_res_t;

  // travels beside the cordic pipeline
  typedef struct packed {
    logic      rot;
    pt2d_res_t alt;
  } pt2d_side_t;

  typedef struct packed {
    logic        flag;
    logic [31:0] val;
  } pt2d_sat_t;

  // clamp to signed 32 bits
  function automatic pt2d_sat_t sat32(input logic signed [63:0] v);
    pt2d_sat_t s;
    if (v > 64'sd2147483647) begin
      s.flag = 1'b1;
      s.val  = 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      s.flag = 1'b1;
      s.val  = 32'h8000_0000;
    end else begin
      s.flag = 1'b0;
      s.val  = v[31:0];
    end
    return s;
  endfunction

  // atan(2^-i) as a binary angle, full turn is 2^32
  function automatic logic signed [31:0] atan_bam(input int unsigned i);
    logic signed [31:0] a;
    case (i)
      0:       a = 32'sd536870912;
      1:       a = 32'sd316933406;
      2:       a = 32'sd167458907;
      3:       a = 32'sd85004756;
      4:       a = 32'sd42667331;
      5:       a = 32'sd21354465;
      6:       a = 32'sd10679838;
      7:       a = 32'sd5340245;
      8:       a = 32'sd2670163;
      9:       a = 32'sd1335087;
      10:      a = 32'sd667544;
      11:      a = 32'sd333772;
      12:      a = 32'sd166886;
      13:      a = 32'sd83443;
      14:      a = 32'sd41721;
      15:      a = 32'sd20860;
      16:      a = 32'sd10430;
      17:      a = 32'sd5215;
      18:      a = 32'sd2607;
      19:      a = 32'sd1303;
      20:      a = 32'sd651;
      21:      a = 32'sd325;
      22:      a = 32'sd162;
      23:      a = 32'sd81;
      24:      a = 32'sd40;
      25:      a = 32'sd20;
      26:      a = 32'sd10;
      27:      a = 32'sd5;
      28:      a = 32'sd2;
      29:      a = 32'sd1;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### hdl/point_transform_2d_top.sv
// ----------------------------------------------------------------------------
// point_transform_2d_top: 2d point rotate / translate / scale / reflect
// fully pipelined, stallable fixed-point transform of one point per clock
// ----------------------------------------------------------------------------
// Unless out_tready stalls, one point enters per clock and one transformed
// point leaves per clock. An accepted item's result reaches out_tvalid via
// six front stages (operand capture, the divide-by-45 reciprocal multiply
// for the angle, the remainder mod 45, angle assembly, quadrant fold, gain
// multiply), one cordic stage per iteration, and the output
// register. All stages advance together; a one-item skid register behind the
// output register catches the result that reaches the end of the pipeline
// while the output register waits on out_tready, after which in_tready
// falls until the skid drains. Rotation takes an angle in degrees (any
// value, reduced modulo 360); translate, scale and the two reflections run
// in the front stages and ride along beside the cordic. Results that leave
// the signed 32-bit range clamp and set the saturated flag in out_tuser.
// Unknown operation codes pass the point through unchanged.
`default_nettype none

module point_transform_2d_top #(
  parameter int unsigned CORDIC_STAGES = 16,  // 8 .. 32
  parameter int unsigned FRAC_BITS     = 16   // 8 .. 24
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input items
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // x_in, y_in, operand_a, operand_b
  input  wire logic [2:0]   in_tuser,   // operation
  // result items
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata,  // x_out, y_out
  output logic [0:0]        out_tuser   // saturated
);

  // binary angle = floor((angle * 2^ANG_SH + ANG_HALF) / 45) mod 2^32
  localparam int unsigned ANG_SH = 29 - FRAC_BITS;

  // cordic gain compensation, q0.32
  localparam logic [31:0] KGAIN = 32'(64'd2608131497 +
      ((2 * CORDIC_STAGES < 32) ? (64'd1738754331 >> (2 * CORDIC_STAGES)) : 64'd0));
  localparam logic signed [32:0] KGAIN_S = {1'b0, KGAIN};

  localparam logic signed [63:0] SC_HALF  = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [31:0] QTR_TURN = 32'sd1073741824;
  localparam logic signed [pt2d_pkg::CW:0] RND_HALF =
      (pt2d_pkg::CW + 1)'(1) <<< (pt2d_pkg::GUARD - 1);

  // per-remainder term of the binary angle, offset already taken out
  function automatic logic [63:0][31:0] build_ofs_tab();
    logic [63:0][31:0] t;
    t = '0;
    for (int r = 0; r < pt2d_pkg::ANG_DIV; r++) begin
      t[r] = 32'(((64'(r) << ANG_SH) + 64'(pt2d_pkg::ANG_HALF)) / 64'(pt2d_pkg::ANG_DIV)
                 - (64'(pt2d_pkg::ANG_MQ) << ANG_SH));
    end
    return t;
  endfunction

  localparam logic [63:0][31:0] OFS_TAB = build_ofs_tab();

  // whole pipeline moves while the skid register is empty
  logic en;
  logic sk_v_r;
  assign en        = !sk_v_r;
  assign in_tready = en;

  // --------------------------------------------------------------------------
  // stage a: capture operands, offset the angle to a positive value
  // --------------------------------------------------------------------------
  logic               a_v_r;
  logic [2:0]         a_op_r;
  logic signed [31:0] a_x_r, a_y_r, a_a_r, a_b_r;
  logic [32:0]        a_u_r;
  logic [32:0]        a_u_nxt;

  assign a_u_nxt = 33'(34'($signed(in_tdata[95:64])) + pt2d_pkg::ANG_OFS);

  always_ff @(posedge clk) begin
    if (en) begin
      a_op_r <= in_tuser;
      a_x_r  <= in_tdata[31:0];
      a_y_r  <= in_tdata[63:32];
      a_a_r  <= in_tdata[95:64];
      a_b_r  <= in_tdata[127:96];
      a_u_r  <= a_u_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage b: reciprocal multiply for /45, scale products, add/negate ops
  // --------------------------------------------------------------------------
  logic                          b_v_r;
  logic [2:0]                    b_op_r;
  logic signed [31:0]            b_x_r, b_y_r;
  logic [5:0]                    b_ulo_r;
  logic [pt2d_pkg::QW-1:0]       b_q_r;
  logic signed [63:0]            b_px_r, b_py_r;
  logic signed [32:0]            b_ox_r, b_oy_r;
  logic [65:0]                   b_mq;
  logic signed [63:0]            b_px_nxt, b_py_nxt;
  logic signed [32:0]            b_ox_nxt, b_oy_nxt;

  assign b_mq     = 66'(a_u_r) * 66'(pt2d_pkg::DIV_M);
  assign b_px_nxt = a_x_r * a_a_r;
  assign b_py_nxt = a_y_r * a_b_r;

  always_comb begin
    b_ox_nxt = 33'(a_x_r);
    b_oy_nxt = 33'(a_y_r);
    case (a_op_r)
      pt2d_pkg::OP_TRANSLATE: begin
        b_ox_nxt = 33'(a_x_r) + 33'(a_a_r);
        b_oy_nxt = 33'(a_y_r) + 33'(a_b_r);
      end
      pt2d_pkg::OP_REFLECT_X: b_oy_nxt = -33'(a_y_r);
      pt2d_pkg::OP_REFLECT_Y: b_ox_nxt = -33'(a_x_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_op_r  <= a_op_r;
      b_x_r   <= a_x_r;
      b_y_r   <= a_y_r;
      b_ulo_r <= a_u_r[5:0];
      b_q_r   <= b_mq[65:pt2d_pkg::DIV_SH];
      b_px_r  <= b_px_nxt;
      b_py_r  <= b_py_nxt;
      b_ox_r  <= b_ox_nxt;
      b_oy_r  <= b_oy_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage c: remainder mod 45, finish and clamp the non-rotate results
  // --------------------------------------------------------------------------
  logic                    c_v_r;
  logic signed [31:0]      c_x_r, c_y_r;
  logic [pt2d_pkg::QW-1:0] c_q_r;
  logic [5:0]              c_r_r;
  pt2d_pkg::pt2d_side_t    c_side_r;
  logic [5:0]              c_r_nxt;
  logic signed [63:0]      c_sx, c_sy;
  pt2d_pkg::pt2d_sat_t     c_cx, c_cy;
  pt2d_pkg::pt2d_side_t    c_side_nxt;

  // remainder is below 45, so six bits of the difference suffice
  assign c_r_nxt = b_ulo_r - 6'(b_q_r[5:0] * 6'(pt2d_pkg::ANG_DIV));
  assign c_sx    = (b_px_r + SC_HALF) >>> FRAC_BITS;
  assign c_sy    = (b_py_r + SC_HALF) >>> FRAC_BITS;

  always_comb begin
    if (b_op_r == pt2d_pkg::OP_SCALE) begin
      c_cx = pt2d_pkg::sat32(c_sx);
      c_cy = pt2d_pkg::sat32(c_sy);
    end else begin
      c_cx = pt2d_pkg::sat32(64'(b_ox_r));
      c_cy = pt2d_pkg::sat32(64'(b_oy_r));
    end
    c_side_nxt.rot     = (b_op_r == pt2d_pkg::OP_ROTATE);
    c_side_nxt.alt.x   = c_cx.val;
    c_side_nxt.alt.y   = c_cy.val;
    c_side_nxt.alt.sat = c_cx.flag | c_cy.flag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_x_r    <= b_x_r;
      c_y_r    <= b_y_r;
      c_q_r    <= b_q_r;
      c_r_r    <= c_r_nxt;
      c_side_r <= c_side_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage d: assemble the 32-bit binary angle
  // --------------------------------------------------------------------------
  logic                 d_v_r;
  logic signed [31:0]   d_x_r, d_y_r, d_z_r;
  pt2d_pkg::pt2d_side_t d_side_r;
  logic [31:0]          d_z_nxt;

  assign d_z_nxt = 32'(64'(c_q_r) << ANG_SH) + OFS_TAB[c_r_r];

  always_ff @(posedge clk) begin
    if (en) begin
      d_x_r    <= c_x_r;
      d_y_r    <= c_y_r;
      d_z_r    <= d_z_nxt;
      d_side_r <= c_side_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage e: fold the angle into +-90 degrees, negate the point when folded
  // --------------------------------------------------------------------------
  logic                 e_v_r;
  logic signed [32:0]   e_x_r, e_y_r;
  logic signed [31:0]   e_z_r;
  pt2d_pkg::pt2d_side_t e_side_r;
  logic                 e_flip;

  // adding or removing half a turn only toggles the top bit here
  assign e_flip = (d_z_r > QTR_TURN) || (d_z_r < -QTR_TURN);

  always_ff @(posedge clk) begin
    if (en) begin
      e_x_r    <= e_flip ? -33'(d_x_r) : 33'(d_x_r);
      e_y_r    <= e_flip ? -33'(d_y_r) : 33'(d_y_r);
      e_z_r    <= e_flip ? {~d_z_r[31], d_z_r[30:0]} : d_z_r;
      e_side_r <= d_side_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage f: gain precompensation multiply
  // --------------------------------------------------------------------------
  logic                 f_v_r;
  logic signed [65:0]   f_px_r, f_py_r;
  logic signed [31:0]   f_z_r;
  pt2d_pkg::pt2d_side_t f_side_r;
  logic signed [65:0]   f_px_nxt, f_py_nxt;

  assign f_px_nxt = e_x_r * KGAIN_S;
  assign f_py_nxt = e_y_r * KGAIN_S;

  always_ff @(posedge clk) begin
    if (en) begin
      f_px_r   <= f_px_nxt;
      f_py_r   <= f_py_nxt;
      f_z_r    <= e_z_r;
      f_side_r <= e_side_r;
    end
  end

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_tvalid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
      e_v_r <= d_v_r;
      f_v_r <= e_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // cordic iterations; the floor shift by 32-GUARD is a bit select
  // --------------------------------------------------------------------------
  logic                           cor_v;
  logic signed [pt2d_pkg::CW-1:0] cor_x, cor_y;
  pt2d_pkg::pt2d_side_t           cor_side;

  pt2d_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_v_r),
    .in_x      (f_px_r[32 - pt2d_pkg::GUARD + pt2d_pkg::CW - 1 : 32 - pt2d_pkg::GUARD]),
    .in_y      (f_py_r[32 - pt2d_pkg::GUARD + pt2d_pkg::CW - 1 : 32 - pt2d_pkg::GUARD]),
    .in_z      (f_z_r),
    .in_side   (f_side_r),
    .out_valid (cor_v),
    .out_x     (cor_x),
    .out_y     (cor_y),
    .out_side  (cor_side)
  );

  // --------------------------------------------------------------------------
  // round off the guard bits, clamp, pick rotate or pass-along result
  // --------------------------------------------------------------------------
  logic signed [pt2d_pkg::CW:0] fin_sx, fin_sy;
  pt2d_pkg::pt2d_sat_t          fin_cx, fin_cy;
  pt2d_pkg::pt2d_res_t          fin_d;

  assign fin_sx = ((pt2d_pkg::CW + 1)'(cor_x) + RND_HALF) >>> pt2d_pkg::GUARD;
  assign fin_sy = ((pt2d_pkg::CW + 1)'(cor_y) + RND_HALF) >>> pt2d_pkg::GUARD;
  assign fin_cx = pt2d_pkg::sat32(64'(fin_sx));
  assign fin_cy = pt2d_pkg::sat32(64'(fin_sy));

  always_comb begin
    if (cor_side.rot) begin
      fin_d.x   = fin_cx.val;
      fin_d.y   = fin_cy.val;
      fin_d.sat = fin_cx.flag | fin_cy.flag;
    end else begin
      fin_d = cor_side.alt;
    end
  end

  // --------------------------------------------------------------------------
  // output register with one skid entry behind it
  // --------------------------------------------------------------------------
  logic                out_v_r, out_v_nxt, sk_v_nxt;
  pt2d_pkg::pt2d_res_t out_d_r, out_d_nxt, sk_d_r, sk_d_nxt;

  always_comb begin
    out_v_nxt = out_v_r;
    out_d_nxt = out_d_r;
    sk_v_nxt  = sk_v_r;
    sk_d_nxt  = sk_d_r;
    if (sk_v_r) begin
      // pipeline frozen, drain the skid into the output register
      if (out_tready) begin
        out_d_nxt = sk_d_r;
        sk_v_nxt  = 1'b0;
      end
    end else begin
      if (out_v_r && out_tready) begin
        out_v_nxt = 1'b0;
      end
      if (cor_v) begin
        if (out_v_r && !out_tready) begin
          sk_v_nxt = 1'b1;
          sk_d_nxt = fin_d;
        end else begin
          out_v_nxt = 1'b1;
          out_d_nxt = fin_d;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r <= out_d_nxt;
    sk_d_r  <= sk_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_d_r.y, out_d_r.x};
  assign out_tuser  = out_d_r.sat;

endmodule

`default_nettype wire

### hdl/pt2d_cordic.sv
// ----------------------------------------------------------------------------
// pt2d_cordic: pipelined cordic rotation, one stage per iteration
// each stage is one add/sub on x and y, all but the last also on the residual angle
// ----------------------------------------------------------------------------
`default_nettype none

module pt2d_cordic #(
  parameter int unsigned STAGES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic signed [pt2d_pkg::CW-1:0]    in_x,
  input  wire logic signed [pt2d_pkg::CW-1:0]    in_y,
  input  wire logic signed [31:0]                in_z,
  input  wire pt2d_pkg::pt2d_side_t              in_side,
  output logic                                   out_valid,
  output logic signed [pt2d_pkg::CW-1:0]         out_x,
  output logic signed [pt2d_pkg::CW-1:0]         out_y,
  output pt2d_pkg::pt2d_side_t                   out_side
);

  logic                           v_r    [STAGES];
  logic signed [pt2d_pkg::CW-1:0] x_r    [STAGES];
  logic signed [pt2d_pkg::CW-1:0] y_r    [STAGES];
  pt2d_pkg::pt2d_side_t           side_r [STAGES];
  logic signed [31:0]             z_r    [STAGES-1];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic                           vi;
    logic signed [pt2d_pkg::CW-1:0] xi, yi, x_nxt, y_nxt;
    logic signed [31:0]             zi;
    pt2d_pkg::pt2d_side_t           si;

    if (i == 0) begin : g_first
      assign vi = in_valid;
      assign xi = in_x;
      assign yi = in_y;
      assign zi = in_z;
      assign si = in_side;
    end else begin : g_next
      assign vi = v_r[i-1];
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign si = side_r[i-1];
    end

    // rotate toward zero residual angle
    always_comb begin
      if (zi >= 32'sd0) begin
        x_nxt = xi - (yi >>> i);
        y_nxt = yi + (xi >>> i);
      end else begin
        x_nxt = xi + (yi >>> i);
        y_nxt = yi - (xi >>> i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]    <= x_nxt;
        y_r[i]    <= y_nxt;
        side_r[i] <= si;
      end
    end

    // last stage needs no residual angle
    if (i < STAGES - 1) begin : g_z
      logic signed [31:0] z_nxt;
      assign z_nxt = (zi >= 32'sd0) ? zi - pt2d_pkg::atan_bam(i)
                                    : zi + pt2d_pkg::atan_bam(i);
      always_ff @(posedge clk) begin
        if (en) begin
          z_r[i] <= z_nxt;
        end
      end
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign out_x     = x_r[STAGES-1];
  assign out_y     = y_r[STAGES-1];
  assign out_side  = side_r[STAGES-1];

endmodule

`default_nettype wire
